### hw/rtl/tsm_pkg.sv
// Shared types, constants and saturating arithmetic helpers for the two-spring RK4 integrator.
package tsm_pkg;

    localparam int WORD_W = 32;
    localparam int FRAC_W = 24;
    localparam int PROD_W = 2 * WORD_W;

    localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    // Division by six: floor(n * DIV6_RECIP / 2^DIV6_SHIFT) equals floor(n / 6) for n < 2^25.
    // Wider numerators are split at DIV6_SPLIT and divided in two pieces.
    localparam logic [WORD_W-1:0] DIV6_RECIP = 32'h00AA_AAAB;
    localparam int                DIV6_SHIFT = 26;
    localparam int                DIV6_SPLIT = 16;

    // Request kinds carried in tuser.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    typedef enum logic [2:0] {
        CFG_SPRING_K   = 3'd0,
        CFG_REST_LEN   = 3'd1,
        CFG_ANCHOR_AX  = 3'd2,
        CFG_ANCHOR_AY  = 3'd3,
        CFG_ANCHOR_BX  = 3'd4,
        CFG_ANCHOR_BY  = 3'd5,
        CFG_INV_MASS   = 3'd6,
        CFG_TIME_STEP  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic                     clip;
        logic signed [WORD_W-1:0] val;
    } t_sres;

    function automatic logic [WORD_W-1:0] mag(logic signed [WORD_W-1:0] v);
        return v[WORD_W-1] ? (~v + WORD_W'(1)) : v;
    endfunction

    function automatic t_sres sat_add(logic signed [WORD_W-1:0] a,
                                      logic signed [WORD_W-1:0] b);
        logic signed [WORD_W:0] s;
        t_sres r;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        r.clip = (s[WORD_W] != s[WORD_W-1]);
        if (!r.clip) begin
            r.val = s[WORD_W-1:0];
        end else if (s[WORD_W]) begin
            r.val = WORD_MIN;
        end else begin
            r.val = WORD_MAX;
        end
        return r;
    endfunction

    function automatic t_sres sat_sub(logic signed [WORD_W-1:0] a,
                                      logic signed [WORD_W-1:0] b);
        logic signed [WORD_W:0] s;
        t_sres r;
        s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
        r.clip = (s[WORD_W] != s[WORD_W-1]);
        if (!r.clip) begin
            r.val = s[WORD_W-1:0];
        end else if (s[WORD_W]) begin
            r.val = WORD_MIN;
        end else begin
            r.val = WORD_MAX;
        end
        return r;
    endfunction

    // Signed word from a sign and a wide magnitude, clipped to the word range.
    function automatic t_sres from_mag(logic neg, logic [PROD_W-1:0] m);
        logic [PROD_W-1:0] lim;
        logic [WORD_W-1:0] mm;
        t_sres r;
        lim = PROD_W'(WORD_MAX) + PROD_W'(neg);
        r.clip = (m > lim);
        mm = r.clip ? lim[WORD_W-1:0] : m[WORD_W-1:0];
        r.val = neg ? (~mm + WORD_W'(1)) : mm;
        return r;
    endfunction

endpackage

### hw/rtl/two_spring_mass_rk4_integrator.sv
// Two-spring mass RK4 integrator: sequencer around one shared multiplier, divider and root unit.
//
//  channel   | direction | handshake              | contents
//  s_axis    | in        | tvalid/tready          | tdata: load pos x, pos y, vel x, vel y
//            |           |                        | tuser: request kind (0 load, 1 step)
//  m_axis    | out       | tvalid/tready          | tdata: pos x, pos y, vel x, vel y
//            |           |                        | tuser: saturated
//  cfg       | in        | i_cfg_we               | i_cfg_idx, i_cfg_data
//
// A load item writes the state and goes straight to the result. A step item runs four
// derivative passes, dominated by the bit-serial divider (four divides per pass)
// and the square root, plus the RK4 updates and four final divides by six,
// each done by reciprocal multiplication on the shared multiplier.
// Reset is synchronous and active low. The input side is ready only between items; a
// finished result waits in the output register while the next item is accepted.
module two_spring_mass_rk4_integrator (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // load_pos_x, load_pos_y, load_vel_x, load_vel_y
    input  logic [0:0]   s_axis_tuser,  // req_type
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,  // out_pos_x, out_pos_y, out_vel_x, out_vel_y
    output logic [0:0]   m_axis_tuser   // saturated
);

    localparam int W = tsm_pkg::WORD_W;
    localparam int P = tsm_pkg::PROD_W;
    localparam int F = tsm_pkg::FRAC_W;

    typedef enum logic [4:0] {
        ST_IDLE, ST_INIT, ST_DIFF, ST_SQX, ST_SQY, ST_SQADD, ST_SQRT, ST_LEN, ST_STR,
        ST_FMUL, ST_FSH, ST_QMUL, ST_QDIV, ST_QACC, ST_IMX, ST_IMXS, ST_IMY, ST_IMYS,
        ST_UACC, ST_UMUL, ST_USH, ST_UQH, ST_UREM, ST_UQL, ST_UFIN, ST_DONE
    } t_state;

    t_state r_state, n_state;
    logic [1:0] r_stage, n_stage;
    logic       r_spr, n_spr;
    logic       r_cmp, n_cmp;
    logic [1:0] r_idx, n_idx;
    logic [5:0] r_cnt, n_cnt;
    logic       r_clip, n_clip;
    logic       r_neg, n_neg;

    logic [30:0] r_k, n_k, r_r0, n_r0, r_im, n_im, r_h, n_h;
    logic signed [W-1:0] r_ax, n_ax, r_ay, n_ay, r_bx, n_bx, r_by, n_by;

    logic signed [W-1:0] r_s [4], n_s [4];
    logic signed [W-1:0] r_t [4], n_t [4];
    logic signed [W-1:0] r_kd [4], n_kd [4];
    logic signed [W-1:0] r_acc [4], n_acc [4];

    logic signed [W-1:0] r_dx, n_dx, r_dy, n_dy, r_str, n_str, r_f, n_f;
    logic signed [W-1:0] r_fx, n_fx, r_fy, n_fy;
    logic [W-1:0] r_len, n_len, r_rem, n_rem, r_dvs, n_dvs;
    logic [P-1:0] r_prod, n_prod, r_sq, n_sq, r_root, n_root, r_bit, n_bit;

    logic         r_ovalid, n_ovalid;
    logic [127:0] r_odata, n_odata;
    logic         r_osat, n_osat;

    logic [W-1:0] w_ma, w_mb;
    logic [P-1:0] w_prod;
    logic         s_fire, m_fire;

    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_fire = r_ovalid && m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_osat;

    // Operand selection for the one shared multiplier.
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            ST_SQX: begin
                w_ma = tsm_pkg::mag(r_dx);
                w_mb = tsm_pkg::mag(r_dx);
            end
            ST_SQY: begin
                w_ma = tsm_pkg::mag(r_dy);
                w_mb = tsm_pkg::mag(r_dy);
            end
            ST_FMUL: begin
                w_ma = {1'b0, r_k};
                w_mb = tsm_pkg::mag(r_str);
            end
            ST_QMUL: begin
                w_ma = tsm_pkg::mag(r_f);
                w_mb = r_cmp ? tsm_pkg::mag(r_dy) : tsm_pkg::mag(r_dx);
            end
            ST_IMX: begin
                w_ma = tsm_pkg::mag(r_fx);
                w_mb = {1'b0, r_im};
            end
            ST_IMY: begin
                w_ma = tsm_pkg::mag(r_fy);
                w_mb = {1'b0, r_im};
            end
            ST_UMUL: begin
                w_ma = {1'b0, r_h};
                w_mb = (r_stage == 2'd3) ? tsm_pkg::mag(r_acc[r_idx])
                                         : tsm_pkg::mag(r_kd[r_idx]);
            end
            ST_UQH: begin
                w_ma = W'(r_prod >> tsm_pkg::DIV6_SPLIT);
                w_mb = tsm_pkg::DIV6_RECIP;
            end
            ST_UQL: begin
                w_ma = r_dvs;
                w_mb = tsm_pkg::DIV6_RECIP;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = P'(w_ma) * P'(w_mb);

    always_comb begin
        tsm_pkg::t_sres    sa;
        tsm_pkg::t_sres    sb;
        logic [W:0]        dtmp;
        logic              dge;
        logic [P-1:0]      rt;
        logic [W-1:0]      rtmp;
        logic              last;
        logic signed [W-1:0] src;

        n_state = r_state;  n_stage = r_stage;  n_spr = r_spr;  n_cmp = r_cmp;
        n_idx = r_idx;  n_cnt = r_cnt;  n_clip = r_clip;  n_neg = r_neg;
        n_k = r_k;  n_r0 = r_r0;  n_im = r_im;  n_h = r_h;
        n_ax = r_ax;  n_ay = r_ay;  n_bx = r_bx;  n_by = r_by;
        n_s = r_s;  n_t = r_t;  n_kd = r_kd;  n_acc = r_acc;
        n_dx = r_dx;  n_dy = r_dy;  n_str = r_str;  n_f = r_f;  n_fx = r_fx;  n_fy = r_fy;
        n_len = r_len;  n_rem = r_rem;  n_dvs = r_dvs;
        n_prod = r_prod;  n_sq = r_sq;  n_root = r_root;  n_bit = r_bit;
        n_ovalid = r_ovalid;  n_odata = r_odata;  n_osat = r_osat;

        sa = '0;
        sb = '0;
        src = '0;
        last = 1'b0;

        // Restoring divider step: shift the numerator out of r_prod, quotient in.
        dtmp = {r_rem, r_prod[P-1]};
        dge  = (dtmp >= {1'b0, r_dvs});

        // Square root step on the sum of squares.
        rt = r_root + r_bit;

        // Remainder of the upper piece in the divide by six.
        rtmp = W'(r_prod >> tsm_pkg::DIV6_SPLIT) - ((r_rem << 2) + (r_rem << 1));

        if (i_cfg_we) begin
            case (tsm_pkg::t_cfg_idx'(i_cfg_idx))
                tsm_pkg::CFG_SPRING_K:  n_k  = i_cfg_data[30:0];
                tsm_pkg::CFG_REST_LEN:  n_r0 = i_cfg_data[30:0];
                tsm_pkg::CFG_ANCHOR_AX: n_ax = i_cfg_data;
                tsm_pkg::CFG_ANCHOR_AY: n_ay = i_cfg_data;
                tsm_pkg::CFG_ANCHOR_BX: n_bx = i_cfg_data;
                tsm_pkg::CFG_ANCHOR_BY: n_by = i_cfg_data;
                tsm_pkg::CFG_INV_MASS:  n_im = i_cfg_data[30:0];
                tsm_pkg::CFG_TIME_STEP: n_h  = i_cfg_data[30:0];
                default: ;
            endcase
        end

        if (m_fire) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_fire) begin
                    n_clip = 1'b0;
                    if (s_axis_tuser[0] == tsm_pkg::REQ_LOAD) begin
                        n_s[0] = s_axis_tdata[31:0];
                        n_s[1] = s_axis_tdata[63:32];
                        n_s[2] = s_axis_tdata[95:64];
                        n_s[3] = s_axis_tdata[127:96];
                        n_state = ST_DONE;
                    end else begin
                        n_t = r_s;
                        n_stage = 2'd0;
                        n_state = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                n_fx = '0;
                n_fy = '0;
                n_spr = 1'b0;
                n_state = ST_DIFF;
            end
            ST_DIFF: begin
                sa = tsm_pkg::sat_sub(r_t[0], r_spr ? r_bx : r_ax);
                sb = tsm_pkg::sat_sub(r_t[1], r_spr ? r_by : r_ay);
                n_dx = sa.val;
                n_dy = sb.val;
                n_clip = r_clip | sa.clip | sb.clip;
                n_state = ST_SQX;
            end
            ST_SQX: begin
                n_sq = w_prod;
                n_state = ST_SQY;
            end
            ST_SQY: begin
                n_prod = w_prod;
                n_state = ST_SQADD;
            end
            ST_SQADD: begin
                n_sq = r_sq + r_prod;
                n_root = '0;
                n_bit = P'(1) << (P - 2);
                n_cnt = '0;
                n_state = ST_SQRT;
            end
            ST_SQRT: begin
                if (r_sq >= rt) begin
                    n_sq = r_sq - rt;
                    n_root = (r_root >> 1) + r_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit = r_bit >> 2;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(P / 2 - 1)) begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN: begin
                // The length is floored at one LSB so the divisor is never zero.
                if (r_root > P'(tsm_pkg::WORD_MAX)) begin
                    n_clip = 1'b1;
                    n_len = tsm_pkg::WORD_MAX;
                end else if (r_root == '0) begin
                    n_len = W'(1);
                end else begin
                    n_len = r_root[W-1:0];
                end
                n_state = ST_STR;
            end
            ST_STR: begin
                sa = tsm_pkg::sat_sub($signed(r_len), $signed({1'b0, r_r0}));
                n_str = sa.val;
                n_clip = r_clip | sa.clip;
                n_state = ST_FMUL;
            end
            ST_FMUL: begin
                n_prod = w_prod;
                n_state = ST_FSH;
            end
            ST_FSH: begin
                sa = tsm_pkg::from_mag(r_str > 0, r_prod >> F);
                n_f = sa.val;
                n_clip = r_clip | sa.clip;
                n_cmp = 1'b0;
                n_state = ST_QMUL;
            end
            ST_QMUL: begin
                n_prod = w_prod;
                n_neg = r_f[W-1] ^ (r_cmp ? r_dy[W-1] : r_dx[W-1]);
                n_dvs = r_len;
                n_rem = '0;
                n_cnt = '0;
                n_state = ST_QDIV;
            end
            ST_QDIV: begin
                n_rem = dge ? W'(dtmp - {1'b0, r_dvs}) : dtmp[W-1:0];
                n_prod = {r_prod[P-2:0], dge};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(P - 1)) begin
                    n_state = ST_QACC;
                end
            end
            ST_QACC: begin
                sa = tsm_pkg::from_mag(r_neg, r_prod);
                sb = tsm_pkg::sat_add(r_cmp ? r_fy : r_fx, sa.val);
                n_clip = r_clip | sa.clip | sb.clip;
                if (!r_cmp) begin
                    n_fx = sb.val;
                    n_cmp = 1'b1;
                    n_state = ST_QMUL;
                end else begin
                    n_fy = sb.val;
                    if (!r_spr) begin
                        n_spr = 1'b1;
                        n_state = ST_DIFF;
                    end else begin
                        n_state = ST_IMX;
                    end
                end
            end
            ST_IMX: begin
                n_prod = w_prod;
                n_state = ST_IMXS;
            end
            ST_IMXS: begin
                sa = tsm_pkg::from_mag(r_fx[W-1], r_prod >> F);
                n_kd[2] = sa.val;
                n_clip = r_clip | sa.clip;
                n_state = ST_IMY;
            end
            ST_IMY: begin
                n_prod = w_prod;
                n_state = ST_IMYS;
            end
            ST_IMYS: begin
                sa = tsm_pkg::from_mag(r_fy[W-1], r_prod >> F);
                n_kd[3] = sa.val;
                n_kd[0] = r_t[2];
                n_kd[1] = r_t[3];
                n_clip = r_clip | sa.clip;
                n_idx = 2'd0;
                n_state = ST_UACC;
            end
            ST_UACC: begin
                // Weighted sum k1 + 2*k2 + 2*k3 + k4, built in the same order as it is used.
                case (r_stage)
                    2'd0: n_acc[r_idx] = r_kd[r_idx];
                    2'd3: begin
                        sa = tsm_pkg::sat_add(r_acc[r_idx], r_kd[r_idx]);
                        n_acc[r_idx] = sa.val;
                        n_clip = r_clip | sa.clip;
                    end
                    default: begin
                        sa = tsm_pkg::sat_add(r_kd[r_idx], r_kd[r_idx]);
                        sb = tsm_pkg::sat_add(r_acc[r_idx], sa.val);
                        n_acc[r_idx] = sb.val;
                        n_clip = r_clip | sa.clip | sb.clip;
                    end
                endcase
                n_state = ST_UMUL;
            end
            ST_UMUL: begin
                src = (r_stage == 2'd3) ? r_acc[r_idx] : r_kd[r_idx];
                n_prod = w_prod;
                n_neg = src[W-1];
                n_state = ST_USH;
            end
            ST_USH: begin
                if (r_stage == 2'd3) begin
                    // Division by 6 * 2^F is a shift followed by a divide by six.
                    n_prod = r_prod >> F;
                    n_state = ST_UQH;
                end else begin
                    sa = tsm_pkg::from_mag(r_neg,
                        (r_stage == 2'd2) ? (r_prod >> F) : (r_prod >> (F + 1)));
                    sb = tsm_pkg::sat_add(r_s[r_idx], sa.val);
                    n_t[r_idx] = sb.val;
                    n_clip = r_clip | sa.clip | sb.clip;
                    last = 1'b1;
                end
            end
            ST_UQH: begin
                // Quotient of the upper piece by reciprocal multiplication.
                n_rem = W'(w_prod >> tsm_pkg::DIV6_SHIFT);
                n_state = ST_UREM;
            end
            ST_UREM: begin
                // Carry the small remainder into the lower piece.
                n_dvs = {rtmp[W-tsm_pkg::DIV6_SPLIT-1:0], r_prod[tsm_pkg::DIV6_SPLIT-1:0]};
                n_state = ST_UQL;
            end
            ST_UQL: begin
                n_prod = (P'(r_rem) << tsm_pkg::DIV6_SPLIT) + (w_prod >> tsm_pkg::DIV6_SHIFT);
                n_state = ST_UFIN;
            end
            ST_UFIN: begin
                sa = tsm_pkg::from_mag(r_neg, r_prod);
                sb = tsm_pkg::sat_add(r_s[r_idx], sa.val);
                n_s[r_idx] = sb.val;
                n_clip = r_clip | sa.clip | sb.clip;
                last = 1'b1;
            end
            ST_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata = {r_s[3], r_s[2], r_s[1], r_s[0]};
                    n_osat = r_clip;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // Move to the next component, the next derivative pass, or the result.
        if (last) begin
            if (r_idx == 2'd3) begin
                if (r_stage == 2'd3) begin
                    n_state = ST_DONE;
                end else begin
                    n_stage = r_stage + 2'd1;
                    n_state = ST_INIT;
                end
            end else begin
                n_idx = r_idx + 2'd1;
                n_state = ST_UACC;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_stage  <= '0;
            r_spr    <= 1'b0;
            r_cmp    <= 1'b0;
            r_idx    <= '0;
            r_cnt    <= '0;
            r_clip   <= 1'b0;
            r_ovalid <= 1'b0;
            r_k      <= 31'd167772160;
            r_r0     <= 31'd16777216;
            r_ax     <= -32'sd16777216;
            r_ay     <= '0;
            r_bx     <= 32'sd16777216;
            r_by     <= '0;
            r_im     <= 31'd16777216;
            r_h      <= 31'd16777;
            r_s      <= '{default: '0};
        end else begin
            r_state  <= n_state;
            r_stage  <= n_stage;
            r_spr    <= n_spr;
            r_cmp    <= n_cmp;
            r_idx    <= n_idx;
            r_cnt    <= n_cnt;
            r_clip   <= n_clip;
            r_ovalid <= n_ovalid;
            r_k      <= n_k;
            r_r0     <= n_r0;
            r_ax     <= n_ax;
            r_ay     <= n_ay;
            r_bx     <= n_bx;
            r_by     <= n_by;
            r_im     <= n_im;
            r_h      <= n_h;
            r_s      <= n_s;
        end
        r_neg   <= n_neg;
        r_t     <= n_t;
        r_kd    <= n_kd;
        r_acc   <= n_acc;
        r_dx    <= n_dx;
        r_dy    <= n_dy;
        r_str   <= n_str;
        r_f     <= n_f;
        r_fx    <= n_fx;
        r_fy    <= n_fy;
        r_len   <= n_len;
        r_rem   <= n_rem;
        r_dvs   <= n_dvs;
        r_prod  <= n_prod;
        r_sq    <= n_sq;
        r_root  <= n_root;
        r_bit   <= n_bit;
        r_odata <= n_odata;
        r_osat  <= n_osat;
    end

    // The divider never runs with a zero divisor.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_QDIV) |-> (r_dvs != '0))
        else $error("divider started with a zero divisor");

    // The root of a sum of two squares of words fits in 32 bits.
    a_root_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LEN) |-> (r_root[P-1:W] == '0))
        else $error("square root result out of range");

    // An accepted item closes the input side until its result has been produced.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> !s_axis_tready)
        else $error("input accepted while an item is in progress");

endmodule
